// ===== rtl/msig_pkg.sv =====
// Package for the masked channel sigmoid unit: field widths, the sigmoid
// table type and the elaboration-time builder of the 257-point table.
// No dependencies.
package msig_pkg;

	localparam int IDX_W     = 10;
	localparam int MASKIN_W  = 8;
	localparam int SAMPLE_W  = 16;
	localparam int VALUE_W   = 16;
	localparam int NUMCH_W   = 11;
	localparam int TAB_LAST  = 256;
	localparam logic [63:0] ENEG = 64'd4034748382;

	typedef logic [TAB_LAST:0][VALUE_W-1:0] sig_tab_t;

	function automatic sig_tab_t build_sig_table();
		sig_tab_t     t;
		logic [127:0] e;
		logic [63:0]  d;
		logic [63:0]  num;
		logic [63:0]  den;
		logic [63:0]  rem;
		logic [63:0]  quo;
		int           j;
		int           b;
		t = '0;
		e = 128'h1_0000_0000;
		for (j = 0; j <= 128; j++) begin
			d   = 64'h1_0000_0000 + e[63:0];
			num = (64'd1 << 49) + d;
			den = d << 1;
			rem = '0;
			quo = '0;
			for (b = 63; b >= 0; b--) begin
				rem = {rem[62:0], num[b]};
				if (rem >= den) begin
					rem    = rem - den;
					quo[b] = 1'b1;
				end
			end
			t[128 + j] = quo[15:0];
			t[128 - j] = 16'(17'h1_0000 - quo[16:0]);
			e = (e * {64'd0, ENEG} + 128'h8000_0000) >> 32;
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/msig_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msig_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/masked_channel_sigmoid_unit.sv =====
// Masked channel sigmoid unit: per-channel gated Q4.12 to Q0.16 sigmoid.
// Depends on msig_pkg and msig_ram (channel mask store).
// Four pipeline stages lie between input acceptance and out_valid; one item per cycle
// sustained unless out_ready stalls, set by the pipeline and the single mask RAM port pair.
// Reset: clears num_channels, then sweeps the mask store to zero, one word per
// cycle over all MAX_CHANNELS/STRIPES words, rounded up (128 by default), with in_ready low.
module masked_channel_sigmoid_unit
	import msig_pkg::*;
#(
	parameter int STRIPES      = 8,
	parameter int MAX_CHANNELS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [IDX_W-1:0]    index,
	input  logic [MASKIN_W-1:0] mask_bits,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VALUE_W-1:0]  value,
	output logic                written,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [NUMCH_W-1:0]  cfg_data
);

	localparam int DEPTH  = (MAX_CHANNELS + STRIPES - 1) / STRIPES;
	localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int PW     = STRIPES > 1 ? $clog2(STRIPES) : 1;
	localparam int SHIFT  = 16;
	localparam int RECIP  = (1 << SHIFT) / STRIPES;
	localparam int PROD_W = IDX_W + SHIFT + 1;
	localparam int QS_W   = IDX_W + 6;

	logic               adv;
	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;
	logic [NUMCH_W-1:0] num_channels_q;

	logic [PROD_W-1:0]  recip_prod;

	logic               valid_s1;
	logic               mode_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [MASKIN_W-1:0] mbits_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic               inrange_s1;
	logic [IDX_W-1:0]   qraw_s1;

	logic [QS_W-1:0]    qs;
	logic [QS_W-1:0]    rem;
	logic [IDX_W-1:0]   word;
	logic [PW-1:0]      pos;
	logic [7:0]         tab_k;
	logic [8:0]         tab_k1;
	logic [31:0]        widx;
	logic [31:0]        wword;
	logic [39:0]        mb_ext;
	logic               wr_in_depth;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [STRIPES-1:0] ram_wdata;
	logic [STRIPES-1:0] ram_rdata;

	logic               valid_s2;
	logic               mode_s2;
	logic               inrange_s2;
	logic [PW-1:0]      pos_s2;
	logic [VALUE_W-1:0] lo_s2;
	logic [VALUE_W-1:0] diff_s2;
	logic [7:0]         frac_s2;

	logic               valid_s3;
	logic               mode_s3;
	logic               active_s3;
	logic [VALUE_W-1:0] lo_s3;
	logic [23:0]        prod_s3;
	logic [23:0]        rnd;

	logic               valid_s4;
	logic [VALUE_W-1:0] value_s4;
	logic               written_s4;

	assign adv       = !valid_s4 || out_ready;
	assign in_ready  = adv && !clr_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_channels_q <= '0;
		end else if (cfg_valid) begin
			num_channels_q <= cfg_data;
		end
	end

	// sweep the mask store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	assign recip_prod = PROD_W'(index) * PROD_W'(RECIP);

	// stage 1: register the item, estimate the stripe word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1    <= mode;
			idx_s1     <= index;
			mbits_s1   <= mask_bits;
			sample_s1  <= sample;
			qraw_s1    <= recip_prod[SHIFT+IDX_W-1:SHIFT];
			inrange_s1 <= ({1'b0, index} < num_channels_q) &&
				(32'(index) < 32'(MAX_CHANNELS));
		end
	end

	always_comb begin
		qs   = QS_W'(qraw_s1) * QS_W'(STRIPES);
		rem  = QS_W'(idx_s1) - qs;
		word = qraw_s1;
		if (rem >= QS_W'(STRIPES)) begin
			rem  = rem - QS_W'(STRIPES);
			word = qraw_s1 + IDX_W'(1);
		end
		pos         = rem[PW-1:0];
		widx        = 32'(idx_s1);
		wword       = 32'(word);
		mb_ext      = {32'd0, mbits_s1};
		wr_in_depth = widx < 32'(DEPTH);
		tab_k       = {~sample_s1[15], sample_s1[14:8]};
		tab_k1      = {1'b0, tab_k} + 9'd1;
	end

	always_comb begin
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = adv && valid_s1 && !mode_s1 && wr_in_depth;
			ram_waddr = widx[AW-1:0];
			ram_wdata = mb_ext[STRIPES-1:0];
		end
	end

	msig_ram #(
		.WIDTH(STRIPES),
		.DEPTH(DEPTH)
	) u_mask_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (adv),
		.raddr(wword[AW-1:0]),
		.rdata(ram_rdata)
	);

	// stage 2: mask read in flight, table lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2    <= mode_s1;
			inrange_s2 <= inrange_s1;
			pos_s2     <= pos;
			lo_s2      <= SIG_TABLE[tab_k];
			diff_s2    <= SIG_TABLE[tab_k1] - SIG_TABLE[tab_k];
			frac_s2    <= sample_s1[7:0];
		end
	end

	// stage 3: pick the channel bit, interpolation product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3   <= mode_s2;
			active_s3 <= inrange_s2 && ram_rdata[pos_s2];
			lo_s3     <= lo_s2;
			prod_s3   <= 24'(diff_s2) * 24'(frac_s2);
		end
	end

	assign rnd = prod_s3 + 24'd128;

	// stage 4: output register, mask-word items drop here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3 && mode_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s4   <= active_s3 ? (lo_s3 + rnd[23:8]) : '0;
			written_s4 <= active_s3;
		end
	end

	assign out_valid = valid_s4;
	assign value     = value_s4;
	assign written   = written_s4;

endmodule

// ===== verif/masked_channel_sigmoid_unit_tb.sv =====
// Testbench for masked_channel_sigmoid_unit: directed and random items, with a
// scoreboard that predicts the gated sigmoid from its own table and mask copy.
// Depends on msig_pkg and the unit RTL.
module masked_channel_sigmoid_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import msig_pkg::*;

	localparam bit MODE_MASK       = 1'b0;
	localparam bit MODE_SAMPLE     = 1'b1;
	localparam int STRIPE_BITS     = 8;
	localparam int MASK_WORDS      = 128;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RANDOM_SEGMENTS = 6;
	localparam int SEGMENT_ITEMS   = 255;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               written;
	} sig_result_t;

	class masked_sigmoid_board;
		localparam bit [95:0] DECAY_STEP = 96'd4034748382;
		logic [VALUE_W-1:0]     sig_points [0:TAB_LAST];
		logic [STRIPE_BITS-1:0] stripe_mask [0:MASK_WORDS-1];
		logic [NUMCH_W-1:0]     channels_in_use;
		sig_result_t            awaited [$];
		int                     mismatches;
		int                     items_seen;
		int                     mask_items;
		int                     results_seen;
		int                     active_results;

		function new();
			bit [95:0]       decay;
			longint unsigned den;
			longint unsigned quot;
			decay = 96'h1_0000_0000;
			for (int j = 0; j <= 128; j++) begin
				den  = 64'h1_0000_0000 + decay[63:0];
				quot = ((64'd1 << 49) + den) / (den << 1);
				sig_points[128 + j] = quot[VALUE_W-1:0];
				sig_points[128 - j] = 16'(17'h1_0000 - quot[16:0]);
				decay = (decay * DECAY_STEP + 96'h8000_0000) >> 32;
			end
			foreach (stripe_mask[w])
				stripe_mask[w] = '0;
			channels_in_use = '0;
			mismatches      = 0;
			items_seen      = 0;
			mask_items      = 0;
			results_seen    = 0;
			active_results  = 0;
		endfunction

		function logic [VALUE_W-1:0] sigmoid_of(logic [SAMPLE_W-1:0] raw);
			logic [SAMPLE_W-1:0] u;
			int unsigned         lo;
			int unsigned         hi;
			int unsigned         y;
			u  = raw ^ 16'h8000;
			lo = sig_points[u[15:8]];
			hi = sig_points[int'(u[15:8]) + 1];
			y  = lo + (((hi - lo) * u[7:0] + 128) >> 8);
			return y[VALUE_W-1:0];
		endfunction

		function void note_item(logic m, logic [IDX_W-1:0] idx,
				logic [MASKIN_W-1:0] bits, logic [SAMPLE_W-1:0] smp);
			sig_result_t r;
			items_seen++;
			if (m == MODE_MASK) begin
				mask_items++;
				if (idx < MASK_WORDS)
					stripe_mask[idx] = bits;
				return;
			end
			r.written = (idx < channels_in_use) &&
				stripe_mask[idx / STRIPE_BITS][idx % STRIPE_BITS];
			r.value = r.written ? sigmoid_of(smp) : '0;
			awaited.push_back(r);
		endfunction

		function void check_result(logic [VALUE_W-1:0] v, logic w);
			sig_result_t exp_r;
			results_seen++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result value=%h written=%b with none outstanding", v, w);
				return;
			end
			exp_r = awaited.pop_front();
			if (exp_r.written)
				active_results++;
			if (v !== exp_r.value || w !== exp_r.written) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d value=%h written=%b, wanted value=%h written=%b",
						results_seen, v, w, exp_r.value, exp_r.written);
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic                       mode;
	logic [IDX_W-1:0]           index;
	logic [MASKIN_W-1:0]        mask_bits;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_ready;
	logic [VALUE_W-1:0]         value;
	logic                       written;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [NUMCH_W-1:0]         cfg_data;

	masked_sigmoid_board board;
	int                  send_idle_pct;
	int                  recv_idle_pct;
	int                  count_settings;
	logic [NUMCH_W-1:0]  seg_count [RANDOM_SEGMENTS];

	masked_channel_sigmoid_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.index     (index),
		.mask_bits (mask_bits),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.written   (written),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_item(mode, index, mask_bits, sample);
		if (arst_n && cfg_valid && cfg_ready) begin
			board.channels_in_use = cfg_data;
			count_settings++;
		end
		if (arst_n && out_valid && out_ready)
			board.check_result(value, written);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_item(input logic m, input logic [IDX_W-1:0] idx,
			input logic [MASKIN_W-1:0] bits, input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		index     <= idx;
		mask_bits <= bits;
		sample    <= smp;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.awaited.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_channel_count(input logic [NUMCH_W-1:0] n);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// span: index range to draw channels from, the current count capped at 1024, or 1024 when it is zero
	task automatic send_random(input int span);
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] smp;
		int                  pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			case ($urandom_range(9))
				0:       idx = IDX_W'($urandom_range(1023, MASK_WORDS));
				1, 2, 3: idx = IDX_W'($urandom_range(MASK_WORDS - 1, 0));
				default: idx = IDX_W'($urandom_range((span - 1) / STRIPE_BITS, 0));
			endcase
			send_item(MODE_MASK, idx, MASKIN_W'($urandom), SAMPLE_W'($urandom));
		end else begin
			idx = (pick < 88) ? IDX_W'($urandom_range(span - 1, 0)) : IDX_W'($urandom);
			case ($urandom_range(9))
				0:       smp = 16'h8000;
				1:       smp = 16'h7FFF;
				default: smp = SAMPLE_W'($urandom);
			endcase
			send_item(MODE_SAMPLE, idx, MASKIN_W'($urandom), smp);
		end
	endtask

	initial begin
		int span;
		board          = new();
		count_settings = 0;
		send_idle_pct  = 15;
		recv_idle_pct  = 80;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		mode      <= MODE_MASK;
		index     <= '0;
		mask_bits <= '0;
		sample    <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		seg_count = '{11'd1024, 11'($urandom_range(1023, 2)), 11'd2047, 11'd0,
			11'($urandom_range(1024, 1)), 11'd1};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_item(MODE_SAMPLE, 10'd0, 8'h00, 16'h0000);
		write_channel_count(11'd1024);
		send_item(MODE_SAMPLE, 10'd0, 8'hFF, 16'h7FFF);
		send_item(MODE_MASK, 10'd0, 8'h0F, 16'hFFFF);
		send_item(MODE_MASK, 10'd127, 8'h80, 16'h0000);
		send_item(MODE_MASK, 10'd128, 8'hFF, 16'h0000);
		send_item(MODE_MASK, 10'd1023, 8'hFF, 16'h0000);
		send_item(MODE_SAMPLE, 10'd0, 8'h00, 16'h8000);
		send_item(MODE_SAMPLE, 10'd1, 8'h00, 16'h7FFF);
		send_item(MODE_SAMPLE, 10'd2, 8'h00, 16'h0000);
		send_item(MODE_SAMPLE, 10'd3, 8'h00, 16'h00FF);
		send_item(MODE_SAMPLE, 10'd4, 8'h00, 16'h0000);
		send_item(MODE_SAMPLE, 10'd1023, 8'h00, 16'hFFFF);
		send_item(MODE_SAMPLE, 10'd1022, 8'h00, 16'h1000);
		send_item(MODE_MASK, 10'd1, 8'hAA, 16'h0000);
		send_item(MODE_SAMPLE, 10'd9, 8'h00, 16'h5A5A);
		send_item(MODE_SAMPLE, 10'd8, 8'h00, 16'h5A5A);
		send_item(MODE_MASK, 10'd0, 8'h00, 16'h0000);
		send_item(MODE_SAMPLE, 10'd0, 8'h00, 16'h1234);
		write_channel_count(11'd4);
		send_item(MODE_MASK, 10'd0, 8'hFF, 16'h0000);
		send_item(MODE_SAMPLE, 10'd3, 8'h00, 16'hC000);
		send_item(MODE_SAMPLE, 10'd4, 8'h00, 16'hC000);

		for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 15;
				recv_idle_pct = 80;
			end else if (seg < 4) begin
				send_idle_pct = 80;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_channel_count(seg_count[seg]);
			span = (seg_count[seg] == 0 || seg_count[seg] > 1024) ? 1024 : seg_count[seg];
			repeat (SEGMENT_ITEMS)
				send_random(span);
		end
		drain_pipeline();

		$display("Run covered %0d items (%0d mask items) under %0d channel counts,",
			board.items_seen, board.mask_items, count_settings);
		$display("checking %0d results of which %0d were written, %0d mismatches.",
			board.results_seen, board.active_results, board.mismatches);
		if (board.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/msig_pkg.sv
rtl/msig_ram.sv
rtl/masked_channel_sigmoid_unit.sv
verif/masked_channel_sigmoid_unit_tb.sv
